// ===== rtl/core/frame_timestamp_calendar_assert.svh =====
// Assertion macros for the frame timestamp calendar.
// Each use expects clk_i and rst_ni in the enclosing scope.
`ifndef FRAME_TIMESTAMP_CALENDAR_ASSERT_SVH
`define FRAME_TIMESTAMP_CALENDAR_ASSERT_SVH

// Property must hold at every rising clock edge outside reset.
`define FTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define FTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg
// Types, constants and calendar helper functions for the frame timestamp
// calendar.
// ----------------------------------------------------------------------------
package ftc_pkg;

  // Opcodes
  localparam logic OpLoad    = 1'b0;
  localparam logic OpAdvance = 1'b1;

  // Field limits
  localparam logic [13:0] YearMax   = 14'd9999;
  localparam logic [3:0]  MonthMin  = 4'd1;
  localparam logic [3:0]  MonthMax  = 4'd12;
  localparam logic [4:0]  DayMin    = 5'd1;
  localparam logic [4:0]  DayMax    = 5'd31;
  localparam logic [4:0]  HourMax   = 5'd23;
  localparam logic [5:0]  MinMax    = 6'd59;
  localparam logic [5:0]  SecMax    = 6'd59;
  localparam logic [9:0]  MilliMax  = 10'd999;
  localparam logic [10:0] MilliWrap = 11'd1000;
  localparam logic [19:0] FrameMax  = 20'd999999;
  localparam logic [9:0]  StepMax   = 10'd999;
  localparam logic [9:0]  StepReset = 10'd40;

  // Reciprocal of 100 for years below 10000: q = (y * 5243) >> 19
  localparam logic [12:0] Recip100  = 13'd5243;
  localparam int unsigned RecipShift = 19;

  // Input item
  typedef struct packed {
    logic        opcode;
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
    logic [9:0]  start_millisecond;
    logic [19:0] start_frame;
  } ftc_in_t;

  // Result item
  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [9:0]  cur_millisecond;
    logic [19:0] cur_frame;
  } ftc_out_t;

  // Month lengths, common year
  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Gregorian leap test for years 0..9999
  function automatic logic is_leap(input logic [13:0] year);
    logic [26:0] prod;
    logic [7:0]  cent;
    logic [13:0] hund;
    prod = 27'(year) * 27'(Recip100);
    cent = prod[RecipShift +: 8];
    hund = (14'(cent) << 6) + (14'(cent) << 5) + (14'(cent) << 2);
    return (year[1:0] == 2'b00) && ((year != hund) || (cent[1:0] == 2'b00));
  endfunction

  // Days in a month; out-of-range month reads as January
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [3:0] idx;
    idx = ((month >= MonthMin) && (month <= MonthMax)) ? (month - 4'd1) : 4'd0;
    if ((idx == 4'd1) && leap) begin
      return 5'd29;
    end
    return MonthLen[idx];
  endfunction

endpackage

// ===== rtl/core/frame_timestamp_calendar.sv =====
// ----------------------------------------------------------------------------
// frame_timestamp_calendar
// Per-frame date and time stamp with millisecond resolution and frame count.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall_o is low, and
// returns one timestamp per item from the result register. An item is first
// captured in an input register; once the result register is free, the whole
// carry chain (milliseconds through years, with the leap-year test for
// February) settles in one pass of logic and writes both the calendar state
// and the result register. A load item sets all fields, saturated into their
// ranges; an advance item adds frame_step_ms (used as 999 when larger) and
// counts one frame. frame_step_ms is written through the config port, which
// is always ready, and should only change while no item is in flight.
// ----------------------------------------------------------------------------
module frame_timestamp_calendar (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [9:0]       cfg_data_i,
  // input items
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ftc_pkg::ftc_in_t in_data_i,
  // results
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ftc_pkg::ftc_out_t out_data_o
);

  logic              step_en;
  logic [9:0]        frame_step_ms_q;
  logic              in_valid_q;
  ftc_pkg::ftc_in_t  in_data_q;
  logic              out_valid_q;
  ftc_pkg::ftc_out_t out_data_q;
  ftc_pkg::ftc_out_t state_q;
  ftc_pkg::ftc_out_t state_d;
  logic              out_free;
  logic              in_take;

  // Handshake: result register drains or is empty, then the input stage moves
  assign out_free    = !out_valid_q || !out_stall_i;
  assign step_en     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_step_ms_q <= ftc_pkg::StepReset;
    end else if (cfg_valid_i) begin
      frame_step_ms_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (out_free || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
  end

  // Next calendar state: load with saturation, or advance with carry chain
  always_comb begin
    logic [9:0]  step;
    logic [10:0] ms_sum;
    logic        c_sec, c_min, c_hour, c_day, c_mon, c_year;
    logic [5:0]  day_inc;
    logic [4:0]  dim;

    step    = (frame_step_ms_q > ftc_pkg::StepMax) ? ftc_pkg::StepMax : frame_step_ms_q;
    ms_sum  = {1'b0, state_q.cur_millisecond} + {1'b0, step};
    c_sec   = ms_sum >= ftc_pkg::MilliWrap;
    c_min   = c_sec && (state_q.cur_second == ftc_pkg::SecMax);
    c_hour  = c_min && (state_q.cur_minute == ftc_pkg::MinMax);
    c_day   = c_hour && (state_q.cur_hour == ftc_pkg::HourMax);
    day_inc = {1'b0, state_q.cur_day} + 6'd1;
    dim     = ftc_pkg::days_in(state_q.cur_month, ftc_pkg::is_leap(state_q.cur_year));
    c_mon   = c_day && (day_inc > {1'b0, dim});
    c_year  = c_mon && (state_q.cur_month >= ftc_pkg::MonthMax);

    state_d = state_q;
    if (in_data_q.opcode == ftc_pkg::OpLoad) begin
      state_d.cur_year = (in_data_q.start_year > ftc_pkg::YearMax) ?
                         ftc_pkg::YearMax : in_data_q.start_year;
      state_d.cur_month = (in_data_q.start_month < ftc_pkg::MonthMin) ? ftc_pkg::MonthMin :
                          (in_data_q.start_month > ftc_pkg::MonthMax) ? ftc_pkg::MonthMax :
                          in_data_q.start_month;
      state_d.cur_day = (in_data_q.start_day < ftc_pkg::DayMin) ? ftc_pkg::DayMin :
                        in_data_q.start_day;
      state_d.cur_hour = (in_data_q.start_hour > ftc_pkg::HourMax) ?
                         ftc_pkg::HourMax : in_data_q.start_hour;
      state_d.cur_minute = (in_data_q.start_minute > ftc_pkg::MinMax) ?
                           ftc_pkg::MinMax : in_data_q.start_minute;
      state_d.cur_second = (in_data_q.start_second > ftc_pkg::SecMax) ?
                           ftc_pkg::SecMax : in_data_q.start_second;
      state_d.cur_millisecond = (in_data_q.start_millisecond > ftc_pkg::MilliMax) ?
                                ftc_pkg::MilliMax : in_data_q.start_millisecond;
      state_d.cur_frame = (in_data_q.start_frame > ftc_pkg::FrameMax) ?
                          ftc_pkg::FrameMax : in_data_q.start_frame;
    end else begin
      state_d.cur_frame = (state_q.cur_frame >= ftc_pkg::FrameMax) ?
                          20'd0 : state_q.cur_frame + 20'd1;
      state_d.cur_millisecond = c_sec ? 10'(ms_sum - ftc_pkg::MilliWrap) : ms_sum[9:0];
      if (c_sec) begin
        state_d.cur_second = c_min ? 6'd0 : state_q.cur_second + 6'd1;
      end
      if (c_min) begin
        state_d.cur_minute = c_hour ? 6'd0 : state_q.cur_minute + 6'd1;
      end
      if (c_hour) begin
        state_d.cur_hour = c_day ? 5'd0 : state_q.cur_hour + 5'd1;
      end
      if (c_day) begin
        state_d.cur_day = c_mon ? 5'(day_inc - {1'b0, dim}) : day_inc[4:0];
      end
      if (c_mon) begin
        state_d.cur_month = c_year ? 4'(state_q.cur_month - 4'd11) :
                            state_q.cur_month + 4'd1;
      end
      if (c_year) begin
        state_d.cur_year = (state_q.cur_year >= ftc_pkg::YearMax) ?
                           14'd0 : state_q.cur_year + 14'd1;
      end
    end
  end

  // Calendar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{cur_year: 14'd0, cur_month: 4'd1, cur_day: 5'd1, cur_hour: 5'd0,
                   cur_minute: 6'd0, cur_second: 6'd0, cur_millisecond: 10'd0,
                   cur_frame: 20'd0};
    end else if (step_en) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_data_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/ftc_checker.sv =====
// ----------------------------------------------------------------------------
// ftc_checker
// Port-level checks for the frame timestamp calendar, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_timestamp_calendar_assert.svh"

module ftc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ftc_pkg::ftc_out_t out_data_o
);

  logic in_xfer;
  logic cur_ok;

  assign in_xfer = in_valid_i && !in_stall_o;

  // Every field of a shown result is within its calendar range
  assign cur_ok = (out_data_o.cur_year <= ftc_pkg::YearMax) &&
                  (out_data_o.cur_month >= ftc_pkg::MonthMin) &&
                  (out_data_o.cur_month <= ftc_pkg::MonthMax) &&
                  (out_data_o.cur_day >= ftc_pkg::DayMin) &&
                  (out_data_o.cur_hour <= ftc_pkg::HourMax) &&
                  (out_data_o.cur_minute <= ftc_pkg::MinMax) &&
                  (out_data_o.cur_second <= ftc_pkg::SecMax) &&
                  (out_data_o.cur_millisecond <= ftc_pkg::MilliMax) &&
                  (out_data_o.cur_frame <= ftc_pkg::FrameMax);

  `FTC_ASSERT(a_out_range, out_valid_o |-> cur_ok, "result field out of range")
  // Input backs up only behind a stalled result
  `FTC_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without cause")
  // A transfer in shows a valid result after the input and result registers
  `FTC_ASSERT(a_latency, in_xfer |-> ##2 out_valid_o, "result missing after input transfer")
  // A stalled result stays valid
  `FTC_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o, "stalled result dropped")

endmodule

bind frame_timestamp_calendar ftc_checker u_ftc_checker (.*);

// ===== dv/tb_frame_timestamp_calendar.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_timestamp_calendar
// Self-checking bench for the per-frame timestamp calendar.
// ----------------------------------------------------------------------------
// Load and advance items go in through the valid/stall input channel. A
// calendar model inside the bench predicts every timestamp, and each result
// field is compared in order. The directed part covers saturation of the
// load fields, the frame-step limits, the leap-year rules, a day past the
// end of its month, and the year and frame wraps. The random part runs
// sequences that load a point near a rollover and then advance, with a few
// frame-step settings and some fully random items. Random gaps and output
// stalls are used, with one long output hold and one mid-run drain.
// ----------------------------------------------------------------------------
module tb_frame_timestamp_calendar;

  localparam int unsigned ClkHalf      = 10;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHold     = 80;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned RandomRounds = 8;
  localparam int unsigned RoundItems   = 250;

  localparam int unsigned DaysPerMonth [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [9:0]        cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  ftc_pkg::ftc_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  ftc_pkg::ftc_out_t out_data_o;

  frame_timestamp_calendar DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Expected timestamps, oldest first, and the bench's own calendar
  ftc_pkg::ftc_out_t timestamp_q [$];
  ftc_pkg::ftc_out_t cal_now;
  int unsigned       step_ms;

  // Flow control shared by the sender and the result sink
  bit idle_en;
  bit hold_req;

  int unsigned errors, idle_cycles;
  int unsigned n_loads, n_advances, n_results, n_cfg_writes;
  int unsigned n_day_rolls, n_leap_days, n_year_wraps, n_frame_wraps, n_in_stalls;

  // 20 ns clock
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  function automatic int unsigned clamp(input int unsigned v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit gregorian_leap(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  // Applies one item to the bench calendar and returns the timestamp after it
  function automatic ftc_pkg::ftc_out_t next_timestamp(input ftc_pkg::ftc_in_t item);
    int unsigned yr, mo, dy, hr, mi, se, ms, fr, dim;
    yr = cal_now.cur_year;
    mo = cal_now.cur_month;
    dy = cal_now.cur_day;
    hr = cal_now.cur_hour;
    mi = cal_now.cur_minute;
    se = cal_now.cur_second;
    ms = cal_now.cur_millisecond;
    fr = cal_now.cur_frame;
    if (item.opcode == ftc_pkg::OpLoad) begin
      yr = clamp(item.start_year, 0, ftc_pkg::YearMax);
      mo = clamp(item.start_month, ftc_pkg::MonthMin, ftc_pkg::MonthMax);
      dy = clamp(item.start_day, ftc_pkg::DayMin, ftc_pkg::DayMax);
      hr = clamp(item.start_hour, 0, ftc_pkg::HourMax);
      mi = clamp(item.start_minute, 0, ftc_pkg::MinMax);
      se = clamp(item.start_second, 0, ftc_pkg::SecMax);
      ms = clamp(item.start_millisecond, 0, ftc_pkg::MilliMax);
      fr = clamp(item.start_frame, 0, ftc_pkg::FrameMax);
    end else begin
      fr = (fr >= ftc_pkg::FrameMax) ? 0 : fr + 1;
      if (fr == 0) n_frame_wraps++;
      // carry chain: ms -> s -> min -> h -> day -> month -> year
      ms = ms + clamp(step_ms, 0, ftc_pkg::StepMax);
      if (ms >= 1000) begin
        ms -= 1000;
        se++;
        if (se >= 60) begin
          se -= 60;
          mi++;
          if (mi >= 60) begin
            mi -= 60;
            hr++;
            if (hr >= 24) begin
              hr -= 24;
              dy++;
              n_day_rolls++;
              // February length comes from the year before any carry
              dim = (mo == 2 && gregorian_leap(yr)) ? 29 : DaysPerMonth[mo - 1];
              if (mo == 2 && dy == 29 && dim == 29) n_leap_days++;
              if (dy > dim) begin
                dy -= dim;
                mo++;
                if (mo > 12) begin
                  mo -= 12;
                  yr = (yr >= ftc_pkg::YearMax) ? 0 : yr + 1;
                  if (yr == 0) n_year_wraps++;
                end
              end
            end
          end
        end
      end
    end
    cal_now.cur_year        = 14'(yr);
    cal_now.cur_month       = 4'(mo);
    cal_now.cur_day         = 5'(dy);
    cal_now.cur_hour        = 5'(hr);
    cal_now.cur_minute      = 6'(mi);
    cal_now.cur_second      = 6'(se);
    cal_now.cur_millisecond = 10'(ms);
    cal_now.cur_frame       = 20'(fr);
    return cal_now;
  endfunction

  // Item builders
  function automatic ftc_pkg::ftc_in_t load_item(input int unsigned yr, mo, dy, hr, mi, se,
                                                 ms, fr);
    ftc_pkg::ftc_in_t item;
    item.opcode            = ftc_pkg::OpLoad;
    item.start_year        = 14'(yr);
    item.start_month       = 4'(mo);
    item.start_day         = 5'(dy);
    item.start_hour        = 5'(hr);
    item.start_minute      = 6'(mi);
    item.start_second      = 6'(se);
    item.start_millisecond = 10'(ms);
    item.start_frame       = 20'(fr);
    return item;
  endfunction

  function automatic ftc_pkg::ftc_in_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(ftc_pkg::ftc_in_t)-1:0];
  endfunction

  // Start fields of an advance carry random bits; the block ignores them
  function automatic ftc_pkg::ftc_in_t advance_item();
    ftc_pkg::ftc_in_t item;
    item = noise_item();
    item.opcode = ftc_pkg::OpAdvance;
    return item;
  endfunction

  // Load biased toward month, year and frame rollovers
  function automatic ftc_pkg::ftc_in_t rollover_load();
    int unsigned yr, mo, dy, hr, mi, se, fr;
    case ($urandom_range(0, 3))
      0:       yr = $urandom_range(0, 9999);
      1:       yr = ftc_pkg::YearMax;
      2:       yr = $urandom_range(0, 24) * 400 + 100 * $urandom_range(0, 3);
      default: yr = $urandom_range(0, 2499) * 4;
    endcase
    case ($urandom_range(0, 3))
      0:       mo = 2;
      1:       mo = 12;
      default: mo = $urandom_range(1, 12);
    endcase
    dy = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(27, 31);
    hr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23;
    mi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59;
    se = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59;
    fr = ($urandom_range(0, 3) == 0) ? $urandom_range(999900, 999999)
                                     : $urandom_range(0, 999999);
    return load_item(yr, mo, dy, hr, mi, se, $urandom_range(0, 999), fr);
  endfunction

  // One input transfer; the expectation is recorded at the accepting edge
  task automatic send_item(input ftc_pkg::ftc_in_t item);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    timestamp_q.push_back(next_timestamp(item));
    if (item.opcode == ftc_pkg::OpLoad) n_loads++;
    else n_advances++;
  endtask

  // Stop sending and wait for every outstanding timestamp
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (timestamp_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Only called with nothing in flight
  task automatic write_step(input logic [9:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    step_ms = value;
    n_cfg_writes++;
  endtask

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    ftc_pkg::ftc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (timestamp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
      end else begin
        want = timestamp_q.pop_front();
        check_field("cur_year", want.cur_year, out_data_o.cur_year);
        check_field("cur_month", want.cur_month, out_data_o.cur_month);
        check_field("cur_day", want.cur_day, out_data_o.cur_day);
        check_field("cur_hour", want.cur_hour, out_data_o.cur_hour);
        check_field("cur_minute", want.cur_minute, out_data_o.cur_minute);
        check_field("cur_second", want.cur_second, out_data_o.cur_second);
        check_field("cur_millisecond", want.cur_millisecond, out_data_o.cur_millisecond);
        check_field("cur_frame", want.cur_frame, out_data_o.cur_frame);
      end
    end
  end

  // Result side: random stall per result, plus one long hold on request
  initial begin : result_sink
    int unsigned wait_cycles;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end
      wait_cycles = idle_en ? $urandom_range(0, 7) : 0;
      if (wait_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) n_in_stalls++;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, IdleLimit);
        $display("frame_timestamp_calendar verification failed");
        $finish;
      end
    end
  end

  // Reset values with the default 40 ms step
  task automatic test_reset_state();
    send_item(advance_item());
  endtask

  // Out-of-range start values clamp into range
  task automatic test_load_saturation();
    send_item(load_item(16383, 15, 31, 31, 63, 63, 1023, 1048575));
    send_item(load_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(load_item(9999, 12, 31, 23, 59, 59, 999, 999999));
  endtask

  // Smallest, largest and over-range frame steps
  task automatic test_step_extremes();
    wait_drained();
    write_step(10'd0);
    send_item(advance_item());
    wait_drained();
    write_step(10'd1023);
    send_item(advance_item());
    wait_drained();
    write_step(ftc_pkg::StepMax);
    send_item(advance_item());
  endtask

  // Carry chains at the end of a day, full and one that stops at the second
  task automatic test_rollovers();
    // year and frame wrap together
    send_item(load_item(9999, 12, 31, 23, 59, 59, 999, 999999));
    send_item(advance_item());
    // leap year by 4, then into March
    send_item(load_item(2024, 2, 28, 23, 59, 59, 999, 5));
    send_item(advance_item());
    send_item(load_item(2024, 2, 29, 23, 59, 59, 999, 6));
    send_item(advance_item());
    // century year is common, 400th year is leap
    send_item(load_item(1900, 2, 28, 23, 59, 59, 999, 7));
    send_item(advance_item());
    send_item(load_item(2000, 2, 28, 23, 59, 59, 999, 8));
    send_item(advance_item());
    // day loaded past the month's end
    send_item(load_item(2023, 2, 31, 23, 59, 59, 999, 9));
    send_item(advance_item());
    // carry stops at the second
    send_item(load_item(2023, 4, 30, 23, 59, 58, 999, 10));
    send_item(advance_item());
  endtask

  // Output held off long enough for the input to back up
  task automatic test_output_backpressure();
    wait_drained();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    send_item(rollover_load());
    repeat (59) send_item(($urandom_range(0, 7) == 0) ? rollover_load() : advance_item());
    wait_drained();
    idle_en = 1'b1;
  endtask

  // Sender pauses mid-sequence until everything has come back
  task automatic test_drain_pause();
    send_item(rollover_load());
    repeat (19) send_item(advance_item());
    wait_drained();
    repeat (20) send_item(advance_item());
  endtask

  // Load-then-advance sequences under several steps, with some random items
  task automatic test_random_sequences();
    int unsigned sent, run;
    logic [9:0]  step_pick;
    for (int r = 0; r < RandomRounds; r++) begin
      wait_drained();
      case (r)
        0:       step_pick = ftc_pkg::StepMax;
        1:       step_pick = 10'd0;
        2:       step_pick = 10'd1023;
        3:       step_pick = 10'($urandom_range(500, 999));
        default: step_pick = 10'($urandom_range(0, 1023));
      endcase
      write_step(step_pick);
      idle_en = (r % 3 != 2);
      sent = 0;
      while (sent < RoundItems) begin
        if ($urandom_range(0, 4) != 0) begin
          send_item(rollover_load());
          run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                            : $urandom_range(1, 20);
          repeat (run) send_item(advance_item());
          sent += run + 1;
        end else begin
          send_item(noise_item());
          sent++;
        end
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    cal_now           = '0;
    cal_now.cur_month = ftc_pkg::MonthMin;
    cal_now.cur_day   = ftc_pkg::DayMin;
    step_ms  = ftc_pkg::StepReset;
    idle_en  = 1'b1;
    hold_req = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_load_saturation();
    test_step_extremes();
    test_rollovers();
    test_output_backpressure();
    test_drain_pause();
    test_random_sequences();
    wait_drained();

    if (timestamp_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, timestamp_q.size());
    end
    $display("Covered %0d loads, %0d advances, %0d step writes; %0d results checked.",
             n_loads, n_advances, n_cfg_writes, n_results);
    $display("Day rollovers %0d (leap days %0d), year wraps %0d, frame wraps %0d, %0d %s",
             n_day_rolls, n_leap_days, n_year_wraps, n_frame_wraps, n_in_stalls,
             "input stall cycles.");
    if (errors == 0) begin
      $display("frame_timestamp_calendar verification clean");
    end else begin
      $display("frame_timestamp_calendar verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ftc_pkg.sv
rtl/core/frame_timestamp_calendar.sv
rtl/core/ftc_checker.sv
dv/tb_frame_timestamp_calendar.sv
